@@ hw/rtl/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, command codes and helpers of the RV64 load/store stage.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int StoreBytes = 4096;
  localparam int AddrW      = 12;
  localparam int CmdW       = 4;

  localparam logic [CmdW-1:0] CMD_LB   = 4'd0;
  localparam logic [CmdW-1:0] CMD_LH   = 4'd1;
  localparam logic [CmdW-1:0] CMD_LW   = 4'd2;
  localparam logic [CmdW-1:0] CMD_LD   = 4'd3;
  localparam logic [CmdW-1:0] CMD_LBU  = 4'd4;
  localparam logic [CmdW-1:0] CMD_LHU  = 4'd5;
  localparam logic [CmdW-1:0] CMD_LWU  = 4'd6;
  localparam logic [CmdW-1:0] CMD_SB   = 4'd7;
  localparam logic [CmdW-1:0] CMD_SH   = 4'd8;
  localparam logic [CmdW-1:0] CMD_SW   = 4'd9;
  localparam logic [CmdW-1:0] CMD_SD   = 4'd10;
  localparam logic [CmdW-1:0] CMD_PASS = 4'd11;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_STORE,
    KIND_PASS
  } kind_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic             bubble;
    logic [AddrW-1:0] byte_address;
    logic [63:0]      data_value;
    logic [4:0]       dest_reg;
    logic [31:0]      instr_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0]     out_value;
    logic [CmdW-1:0] out_command;
    logic [4:0]      out_dest_reg;
    logic [31:0]     out_instr_word;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic red_step;
    logic rd_en;
    logic wr_en;
    logic clr_en;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  in_drop;
    kind_e in_kind;
    logic  in_addr_ge;
    kind_e q_kind;
    logic  red_last;
    logic  byte_last;
    logic  clear_last;
  } dp_status_t;

  function automatic kind_e cmd_kind(logic [CmdW-1:0] cmd);
    kind_e k;
    case (cmd)
      CMD_LB, CMD_LH, CMD_LW, CMD_LD,
      CMD_LBU, CMD_LHU, CMD_LWU: k = KIND_LOAD;
      CMD_SB, CMD_SH, CMD_SW, CMD_SD: k = KIND_STORE;
      default: k = KIND_PASS;
    endcase
    return k;
  endfunction

  // index of the last byte of the access
  function automatic logic [2:0] cmd_last(logic [CmdW-1:0] cmd);
    logic [2:0] n;
    case (cmd)
      CMD_LH, CMD_LHU, CMD_SH: n = 3'd1;
      CMD_LW, CMD_LWU, CMD_SW: n = 3'd3;
      CMD_LD, CMD_SD:          n = 3'd7;
      default:                 n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/lss_stream_if.sv @@
// ----------------------------------------------------------------------------
// lss_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lss_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ hw/rtl/lss_ctrl.sv @@
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer of the load/store stage: clearing pass, address reduction,
// byte-serial load/store and hand-off to the output register.
// ----------------------------------------------------------------------------
module lss_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  lss_pkg::dp_status_t    status_i,
  output lss_pkg::ctrl_cmd_t     cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_REDUCE = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_LTAIL  = 3'd4;
  localparam logic [2:0] ST_STORE  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  function automatic logic [2:0] route(lss_pkg::kind_e k);
    logic [2:0] s;
    case (k)
      lss_pkg::KIND_LOAD:  s = ST_LOAD;
      lss_pkg::KIND_STORE: s = ST_STORE;
      default:             s = ST_DONE;
    endcase
    return s;
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && !status_i.in_drop) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.in_addr_ge ? ST_REDUCE : route(status_i.in_kind);
        end
      end
      ST_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (status_i.red_last) begin
          state_d = route(status_i.q_kind);
        end
      end
      ST_LOAD: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.byte_last) begin
          state_d = ST_LTAIL;
        end
      end
      ST_LTAIL: begin
        state_d = ST_DONE;
      end
      ST_STORE: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.byte_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/lss_dp.sv @@
// ----------------------------------------------------------------------------
// lss_dp
// Datapath of the load/store stage: byte store, item registers, address
// reduction, byte assembly with extension and the output register.
// ----------------------------------------------------------------------------
module lss_dp #(
  parameter int STORE_BYTES = lss_pkg::StoreBytes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lss_pkg::in_item_t     in_data_i,
  input  lss_pkg::ctrl_cmd_t    cmd_i,
  output lss_pkg::dp_status_t   status_o,
  output lss_pkg::out_item_t    out_data_o
);

  localparam int PW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int AW = lss_pkg::AddrW;
  localparam int CW = AW + PW + 1;
  localparam int KW = $clog2(AW);

  logic [7:0]              mem [STORE_BYTES];

  logic [lss_pkg::CmdW-1:0] cmd_q;
  logic [4:0]              rd_q;
  logic [31:0]             instr_q;
  logic [63:0]             val_q;
  logic [63:0]             acc_q;
  logic [7:0]              rdata_q;
  logic                    cap_q;
  logic [PW-1:0]           ptr_q;
  logic [PW-1:0]           ptr_inc;
  logic [2:0]              cnt_q;
  logic [AW-1:0]           red_q;
  logic [AW-1:0]           red_next;
  logic [KW-1:0]           k_q;
  logic [CW-1:0]           shifted;
  logic                    advance;
  logic [63:0]             load_val;
  logic [63:0]             res_val;
  lss_pkg::out_item_t      out_q;

  assign advance = cmd_i.rd_en || cmd_i.wr_en || cmd_i.clr_en;
  assign ptr_inc = (ptr_q == PW'(STORE_BYTES - 1)) ? '0 : ptr_q + 1'b1;

  assign shifted  = CW'(STORE_BYTES) << k_q;
  assign red_next = (CW'(red_q) >= shifted) ? red_q - shifted[AW-1:0] : red_q;

  // bytes enter at the top, so byte 0 sits at bit 64 - 8n
  always_comb begin
    case (cmd_q)
      lss_pkg::CMD_LB:  load_val = {{56{acc_q[63]}}, acc_q[63:56]};
      lss_pkg::CMD_LH:  load_val = {{48{acc_q[63]}}, acc_q[63:48]};
      lss_pkg::CMD_LW:  load_val = {{32{acc_q[63]}}, acc_q[63:32]};
      lss_pkg::CMD_LBU: load_val = {56'd0, acc_q[63:56]};
      lss_pkg::CMD_LHU: load_val = {48'd0, acc_q[63:48]};
      lss_pkg::CMD_LWU: load_val = {32'd0, acc_q[63:32]};
      default:          load_val = acc_q;
    endcase
  end

  always_comb begin
    case (lss_pkg::cmd_kind(cmd_q))
      lss_pkg::KIND_LOAD:  res_val = load_val;
      lss_pkg::KIND_STORE: res_val = '0;
      default:             res_val = val_q;
    endcase
  end

  always_comb begin
    status_o.in_drop    = in_data_i.bubble || (in_data_i.instr_word == '0);
    status_o.in_kind    = lss_pkg::cmd_kind(in_data_i.command);
    status_o.in_addr_ge = CW'(in_data_i.byte_address) >= CW'(STORE_BYTES);
    status_o.q_kind     = lss_pkg::cmd_kind(cmd_q);
    status_o.red_last   = (k_q == '0);
    status_o.byte_last  = (cnt_q == lss_pkg::cmd_last(cmd_q));
    status_o.clear_last = (ptr_q == PW'(STORE_BYTES - 1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem[ptr_q] <= 8'd0;
    end else if (cmd_i.wr_en) begin
      mem[ptr_q] <= val_q[7:0];
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
      k_q   <= '0;
      cap_q <= 1'b0;
    end else begin
      cap_q <= cmd_i.rd_en;
      if (cmd_i.capture) begin
        ptr_q <= PW'(in_data_i.byte_address);
        cnt_q <= '0;
        k_q   <= KW'(AW - 1);
      end else if (cmd_i.red_step) begin
        ptr_q <= PW'(red_next);
        k_q   <= k_q - 1'b1;
      end else if (advance) begin
        ptr_q <= ptr_inc;
        if (!cmd_i.clr_en) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= in_data_i.command;
      rd_q    <= in_data_i.dest_reg;
      instr_q <= in_data_i.instr_word;
      val_q   <= in_data_i.data_value;
      red_q   <= in_data_i.byte_address;
    end else begin
      if (cmd_i.red_step) begin
        red_q <= red_next;
      end
      if (cmd_i.wr_en) begin
        val_q <= {8'd0, val_q[63:8]};
      end
    end
    if (cap_q) begin
      acc_q <= {rdata_q, acc_q[63:8]};
    end
    if (cmd_i.finish) begin
      out_q.out_value      <= res_val;
      out_q.out_command    <= cmd_q;
      out_q.out_dest_reg   <= rd_q;
      out_q.out_instr_word <= instr_q;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ hw/rtl/rv64_load_store_stage.sv @@
// ----------------------------------------------------------------------------
// rv64_load_store_stage
// Memory stage of an RV64 pipeline over a byte-addressed little-endian store.
// ----------------------------------------------------------------------------
//  port    dir   payload              notes
//  in_i    sink  lss_pkg::in_item_t   bubbles and zero instructions dropped
//  out_o   src   lss_pkg::out_item_t  registered, one per kept transaction
//
//  Sequence: pass results go straight to the output register; a store or
//  load walks its bytes one at a time over the store's single byte port.
//  An address at or above STORE_BYTES is first reduced by shift-subtract.
//  Reset: clearing pass over all STORE_BYTES bytes, in_i.ready low meanwhile.
//  Stalls: a result waiting on out_o does not block intake; the next result
//  holds in the done state until the output register frees.
module rv64_load_store_stage #(
  parameter int STORE_BYTES = lss_pkg::StoreBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lss_stream_if.sink   in_i,
  lss_stream_if.source out_o
);

  lss_pkg::ctrl_cmd_t  cmd;
  lss_pkg::dp_status_t status;
  lss_pkg::out_item_t  out_data;
  logic                in_ready;
  logic                out_valid;

  lss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lss_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RV64 load/store stage. A short directed table
// covers the access sizes, sign extension, address wrap, store and pass
// results and dropped slots, then random traffic over a few hot address
// windows runs in three idling phases. A byte-image predictor builds the
// expected writebacks, which are matched in order on the output channel.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED_FIRST = 4'd12;
  localparam logic [CmdW-1:0] CMD_UNUSED_LAST  = 4'd15;

  localparam int RandPerPhase  = 641;
  localparam int RxHoldCycles  = 400;
  localparam int WatchdogLimit = 25000;
  localparam int DrainCycles   = 64;

  typedef struct {
    in_item_t    item;
    bit          typed;
    bit          kept;
    logic [63:0] value;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lss_stream_if #(.payload_t(in_item_t))  in_if ();
  lss_stream_if #(.payload_t(out_item_t)) out_if ();

  rv64_load_store_stage u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [7:0] mem_image [StoreBytes];
  out_item_t  pending_writebacks [$];
  dir_row_t   dir_rows [$];
  int         mismatch_count;
  int         tb_phase;
  int         tx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // expected writeback of one accepted transaction; updates the byte image
  function automatic bit mem_stage_result(input in_item_t it, output out_item_t res);
    int          nbytes;
    int          idx;
    bit          is_load;
    bit          is_store;
    bit          sext;
    logic [63:0] v;
    res.out_command    = it.command;
    res.out_dest_reg   = it.dest_reg;
    res.out_instr_word = it.instr_word;
    res.out_value      = '0;
    if (it.bubble || it.instr_word == '0) return 1'b0;
    is_load  = 1'b0;
    is_store = 1'b0;
    sext     = 1'b0;
    nbytes   = 0;
    case (it.command)
      CMD_LB:  begin is_load = 1'b1; sext = 1'b1; nbytes = 1; end
      CMD_LH:  begin is_load = 1'b1; sext = 1'b1; nbytes = 2; end
      CMD_LW:  begin is_load = 1'b1; sext = 1'b1; nbytes = 4; end
      CMD_LD:  begin is_load = 1'b1; nbytes = 8; end
      CMD_LBU: begin is_load = 1'b1; nbytes = 1; end
      CMD_LHU: begin is_load = 1'b1; nbytes = 2; end
      CMD_LWU: begin is_load = 1'b1; nbytes = 4; end
      CMD_SB:  begin is_store = 1'b1; nbytes = 1; end
      CMD_SH:  begin is_store = 1'b1; nbytes = 2; end
      CMD_SW:  begin is_store = 1'b1; nbytes = 4; end
      CMD_SD:  begin is_store = 1'b1; nbytes = 8; end
      default: ;
    endcase
    v = '0;
    for (int i = 0; i < nbytes; i++) begin
      idx = (int'(it.byte_address) + i) % StoreBytes;
      if (is_store) mem_image[idx] = it.data_value[8*i +: 8];
      else v[8*i +: 8] = mem_image[idx];
    end
    if (sext && v[8*nbytes-1]) v = v | ({64{1'b1}} << (8*nbytes - 1));
    if (!is_load && !is_store) v = it.data_value;
    res.out_value = v;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [CmdW-1:0] cmd, input logic bub,
                                  input logic [AddrW-1:0] addr, input logic [63:0] val,
                                  input logic [4:0] rd, input logic [31:0] instr,
                                  input bit typed, input bit kept,
                                  input logic [63:0] value);
    dir_row_t r;
    r.item.command      = cmd;
    r.item.bubble       = bub;
    r.item.byte_address = addr;
    r.item.data_value   = val;
    r.item.dest_reg     = rd;
    r.item.instr_word   = instr;
    r.typed             = typed;
    r.kept              = kept;
    r.value             = value;
    dir_rows.push_back(r);
  endfunction

  function automatic in_item_t random_access();
    in_item_t it;
    int       pick;
    it.data_value = {$urandom(), $urandom()};
    it.dest_reg   = 5'($urandom_range(31));
    it.instr_word = $urandom();
    it.bubble     = 1'b0;
    pick = $urandom_range(99);
    if (pick < 45) it.command = CmdW'($urandom_range(CMD_LWU, CMD_LB));
    else if (pick < 85) it.command = CmdW'($urandom_range(CMD_SD, CMD_SB));
    else if (pick < 93) it.command = CMD_PASS;
    else it.command = CmdW'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
    pick = $urandom_range(99);
    if (pick < 40) it.byte_address = AddrW'($urandom_range(63));
    else if (pick < 55) it.byte_address = AddrW'($urandom_range(StoreBytes - 1, StoreBytes - 8));
    else it.byte_address = AddrW'($urandom_range(StoreBytes - 1));
    pick = $urandom_range(99);
    if (pick < 5) it.bubble = 1'b1;
    else if (pick < 8) it.instr_word = '0;
    return it;
  endfunction

  task automatic send(input in_item_t it, input bit typed, input bit kept,
                      input logic [63:0] value);
    out_item_t res;
    bit        has_res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    has_res = mem_stage_result(it, res);
    if (typed) begin
      has_res       = kept;
      res.out_value = value;
    end
    if (has_res) pending_writebacks.push_back(res);
  endtask

  task automatic drain_writebacks();
    in_if.valid <= 1'b0;
    while (pending_writebacks.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int phase, input int idle_pct);
    in_item_t it;
    int       sent_cnt;
    tb_phase    <= phase;
    tx_idle_pct = idle_pct;
    sent_cnt    = 0;
    while (sent_cnt < RandPerPhase) begin
      it = random_access();
      send(it, 1'b0, 1'b0, '0);
      sent_cnt++;
    end
    drain_writebacks();
  endtask

  // receiver: random back-pressure, plus one long hold at the start of phase 3
  initial begin
    int last_phase;
    int hold_left;
    int idle_pct;
    last_phase = 0;
    hold_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tb_phase == 3 && last_phase != 3) hold_left = RxHoldCycles;
      last_phase = tb_phase;
      idle_pct = (tb_phase == 1) ? 46 : (tb_phase == 2) ? 19 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // writeback checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_writebacks.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected writeback value=%h cmd=%0d rd=%0d instr=%h", $time,
                 out_if.data.out_value, out_if.data.out_command,
                 out_if.data.out_dest_reg, out_if.data.out_instr_word);
      end else begin
        want = pending_writebacks.pop_front();
        if (out_if.data !== want) begin
          mismatch_count++;
          $display("%0t: writeback mismatch", $time);
          $display("  exp value=%h cmd=%0d rd=%0d instr=%h", want.out_value,
                   want.out_command, want.out_dest_reg, want.out_instr_word);
          $display("  got value=%h cmd=%0d rd=%0d instr=%h", out_if.data.out_value,
                   out_if.data.out_command, out_if.data.out_dest_reg,
                   out_if.data.out_instr_word);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    mismatch_count = 0;
    tx_idle_pct    = 19;
    tb_phase       <= 1;
    foreach (mem_image[i]) mem_image[i] = 8'h00;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // cleared store, a doubleword store then every load width over it
    add_row(CMD_LD, 1'b0, 12'h000, 64'h0, 5'd1, 32'h0000_3003, 1'b1, 1'b1, 64'h0);
    add_row(CMD_LB, 1'b0, 12'hFFF, '1, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'h0);
    add_row(CMD_SD, 1'b0, 12'h000, 64'hF0E1_D2C3_B4A5_9687, 5'd2, 32'h0000_3023,
            1'b1, 1'b1, 64'h0);
    add_row(CMD_LB,  1'b0, 12'h000, 64'h0, 5'd3, 32'h0000_0003, 1'b0, 1'b0, '0);
    add_row(CMD_LBU, 1'b0, 12'h000, 64'h0, 5'd4, 32'h0000_4003, 1'b0, 1'b0, '0);
    add_row(CMD_LH,  1'b0, 12'h000, 64'h0, 5'd5, 32'h0000_1003, 1'b0, 1'b0, '0);
    add_row(CMD_LHU, 1'b0, 12'h000, 64'h0, 5'd6, 32'h0000_5003, 1'b0, 1'b0, '0);
    add_row(CMD_LW,  1'b0, 12'h000, 64'h0, 5'd7, 32'h0000_2003, 1'b0, 1'b0, '0);
    add_row(CMD_LWU, 1'b0, 12'h000, 64'h0, 5'd8, 32'h0000_6003, 1'b0, 1'b0, '0);
    add_row(CMD_LD,  1'b0, 12'h000, 64'h0, 5'd9, 32'h0000_3003, 1'b0, 1'b0, '0);
    // accesses across the top of the store
    add_row(CMD_SD, 1'b0, 12'hFFC, 64'h7F6E_5D4C_3B2A_1908, 5'd10, 32'h0000_3023,
            1'b1, 1'b1, 64'h0);
    add_row(CMD_LD, 1'b0, 12'hFFC, 64'h0, 5'd11, 32'h0000_3003, 1'b0, 1'b0, '0);
    add_row(CMD_LW, 1'b0, 12'hFFE, 64'h0, 5'd12, 32'h0000_2003, 1'b0, 1'b0, '0);
    add_row(CMD_LH, 1'b0, 12'hFFF, 64'h0, 5'd13, 32'h0000_1003, 1'b0, 1'b0, '0);
    // all-ones narrow stores, read back with sign and zero extension
    add_row(CMD_SB, 1'b0, 12'h064, '1, 5'd14, 32'h0000_0023, 1'b1, 1'b1, 64'h0);
    add_row(CMD_SH, 1'b0, 12'h0C8, '1, 5'd15, 32'h0000_1023, 1'b1, 1'b1, 64'h0);
    add_row(CMD_SW, 1'b0, 12'h12C, '1, 5'd16, 32'h0000_2023, 1'b1, 1'b1, 64'h0);
    add_row(CMD_LB,  1'b0, 12'h064, 64'h0, 5'd17, 32'h0000_0003, 1'b0, 1'b0, '0);
    add_row(CMD_LHU, 1'b0, 12'h0C8, 64'h0, 5'd18, 32'h0000_5003, 1'b0, 1'b0, '0);
    add_row(CMD_LW,  1'b0, 12'h12C, 64'h0, 5'd19, 32'h0000_2003, 1'b0, 1'b0, '0);
    // pass-through, unused codes, dropped slots and a load over their address
    add_row(CMD_PASS, 1'b0, 12'hFFF, '1, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b1, '1);
    add_row(CMD_PASS, 1'b0, 12'h000, 64'h0, 5'd0, 32'h0000_0001, 1'b1, 1'b1, 64'h0);
    add_row(CMD_UNUSED_FIRST, 1'b0, 12'h000, 64'hA5A5_5A5A_A5A5_5A5A, 5'd20,
            32'h0000_0013, 1'b1, 1'b1, 64'hA5A5_5A5A_A5A5_5A5A);
    add_row(CMD_UNUSED_LAST, 1'b0, 12'h000, 64'h0123_4567_89AB_CDEF, 5'd21,
            32'h0000_0033, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF);
    add_row(CMD_SD, 1'b1, 12'h000, 64'h0, 5'd22, 32'h0000_3023, 1'b1, 1'b0, '0);
    add_row(CMD_SD, 1'b0, 12'h000, 64'h0, 5'd23, 32'h0000_0000, 1'b1, 1'b0, '0);
    add_row(CMD_LD, 1'b0, 12'h000, 64'h0, 5'd24, 32'h0000_3003, 1'b0, 1'b0, '0);

    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].kept,
                               dir_rows[i].value);
    drain_writebacks();

    random_phase(1, 19);
    random_phase(2, 46);
    random_phase(3, 0);

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_writebacks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
